@@ rtl/core/modular_exponentiation_macros.svh @@
// Assertion macros for the modular exponentiation block.
// Included by the top level; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MEXP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MEXP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by the controller, the datapath and the top level.
package mexp_pkg;

   localparam int DATA_W        = 32;
   localparam int WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_RUN,
      ST_CHECK,
      ST_MUL_RUN,
      ST_SQ_START,
      ST_SQR_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULT,
      OP_SQUARE
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul_init;
      logic   mul_step;
      logic   mul_last;
      logic   exp_shift;
      logic   out_load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic m_zero;
      logic exp_zero;
      logic exp_bit0;
      logic exp_one;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/mexp_ctrl.sv @@
// Sequencer for the modular exponentiation block: state machine and step counter.
// Depends on mexp_pkg; drives the datapath through cmd_type, reads status_type.
module mexp_ctrl #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mexp_pkg::status_type   status,
   output mexp_pkg::cmd_type      cmd
);
   import mexp_pkg::*;

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           cnt_last;

   assign cnt_last = (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // one multiplier bit per cycle; clear between products
   always_comb begin
      if (cmd.mul_step && !cnt_last) begin
         cnt_in = cnt_ff + CW'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.m_zero ? ST_FINISH : ST_RED_RUN;
            end
         end
         ST_RED_RUN: begin
            if (cnt_last) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else if (status.exp_bit0) begin
               state_in = ST_MUL_RUN;
            end else begin
               state_in = ST_SQR_RUN;
            end
         end
         ST_MUL_RUN: begin
            if (cnt_last) state_in = ST_SQ_START;
         end
         ST_SQ_START: begin
            // skip the square after the top exponent bit
            state_in = status.exp_one ? ST_CHECK : ST_SQR_RUN;
         end
         ST_SQR_RUN: begin
            if (cnt_last) state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.op     = OP_REDUCE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_RED_RUN: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = cnt_last;
            cmd.op       = OP_REDUCE;
         end
         ST_CHECK: begin
            cmd.mul_init = !status.exp_zero;
            cmd.op       = status.exp_bit0 ? OP_MULT : OP_SQUARE;
         end
         ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = cnt_last;
            cmd.op       = OP_MULT;
         end
         ST_SQ_START: begin
            cmd.exp_shift = status.exp_one;
            cmd.mul_init  = !status.exp_one;
            cmd.op        = OP_SQUARE;
         end
         ST_SQR_RUN: begin
            cmd.mul_step  = 1'b1;
            cmd.mul_last  = cnt_last;
            cmd.exp_shift = cnt_last;
            cmd.op        = OP_SQUARE;
         end
         ST_FINISH: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/mexp_dp.sv @@
// Datapath for the modular exponentiation block: modulus register, operand
// registers, bit-serial modular multiplier and output register. Depends on mexp_pkg.
module mexp_dp #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mexp_pkg::DATA_W-1:0]   csr_wdata,
   input  logic [mexp_pkg::DATA_W-1:0]   base,
   input  logic [mexp_pkg::DATA_W-1:0]   exponent,
   input  mexp_pkg::cmd_type             cmd,
   output mexp_pkg::status_type          status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mexp_pkg::DATA_W-1:0]   rsp_tdata
);
   import mexp_pkg::*;

   localparam int W = WIDTH;

   logic [W-1:0]      m_ff, m_in;
   logic [W-1:0]      a_ff, a_in;
   logic [W-1:0]      b_ff, b_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      sq_ff, sq_in;
   logic [W-1:0]      res_ff, res_in;
   logic [W-1:0]      exp_ff, exp_in;
   logic [DATA_W-1:0] out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              m_is_one;
   logic [W-1:0]      one_m;
   logic [W+1:0]      sum;
   logic [W+1:0]      m1;
   logic [W+1:0]      m2;
   logic [W-1:0]      step_res;

   assign m_is_one = (m_ff == W'(1));
   assign one_m    = m_is_one ? '0 : W'(1);

   // acc <- (2*acc + a*bit) mod m; the sum stays below 3m
   assign sum = {1'b0, acc_ff, 1'b0} + (b_ff[W-1] ? {2'b00, a_ff} : '0);
   assign m1  = {2'b00, m_ff};
   assign m2  = {1'b0, m_ff, 1'b0};

   always_comb begin
      if (sum >= m2) begin
         step_res = W'(sum - m2);
      end else if (sum >= m1) begin
         step_res = W'(sum - m1);
      end else begin
         step_res = W'(sum);
      end
   end

   always_comb begin
      m_in = m_ff;
      if (csr_we) m_in = W'(csr_wdata);
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      sq_in  = sq_ff;
      res_in = res_ff;
      exp_in = exp_ff;
      if (cmd.load) begin
         // reduce the base: multiply it by one, bit by bit
         a_in   = one_m;
         b_in   = W'(base);
         acc_in = '0;
         res_in = W'(1);
         exp_in = W'(exponent);
      end
      if (cmd.mul_init) begin
         acc_in = '0;
         case (cmd.op)
            OP_MULT: begin
               a_in = m_is_one ? '0 : res_ff;
               b_in = sq_ff;
            end
            default: begin
               a_in = sq_ff;
               b_in = sq_ff;
            end
         endcase
      end
      if (cmd.mul_step) begin
         acc_in = step_res;
         b_in   = {b_ff[W-2:0], 1'b0};
         if (cmd.mul_last) begin
            case (cmd.op)
               OP_MULT: res_in = step_res;
               default: sq_in  = step_res;
            endcase
         end
      end
      if (cmd.exp_shift) exp_in = {1'b0, exp_ff[W-1:1]};
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (cmd.out_load) begin
         out_in       = (m_ff == '0) ? '0 : DATA_W'(res_ff);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff         <= W'(2);
         out_valid_ff <= 1'b0;
      end else begin
         m_ff         <= m_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      res_ff <= res_in;
      exp_ff <= exp_in;
      out_ff <= out_in;
   end

   assign status.m_zero   = (m_ff == '0);
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_bit0 = exp_ff[0];
   assign status.exp_one  = (exp_ff[W-1:1] == '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// Modular exponentiation top level: base^exponent mod modulus, right to left.
// Depends on mexp_pkg, mexp_ctrl, mexp_dp and modular_exponentiation_macros.svh.
//
// Usage:
//   csr_we/csr_wdata write the modulus (reset value 2); write it only while idle.
//   The req channel takes one item (base, exponent) at a time; req_tready is
//   high only while the sequencer is idle.
//   The rsp channel gives exactly one result per item from an output register.
// Sequence:
//   load, reduction of the base, then per exponent bit a check state, the multiply
//   plus a start state for the square when the bit is set, and the square
//   (skipped after the top bit); a last check state and a state to hand the
//   result over. The bit-serial modular multiplier takes one multiplier bit per
//   cycle.
//   A zero modulus skips all products and yields 0.
// Reset clears the sequencer and the output valid and sets the modulus to 2.
// When rsp_tready is low the result holds; the next item can still be taken,
// but its result waits in the sequencer until the output register is free.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mexp_pkg::DATA_W-1:0]     csr_wdata,   // modulus
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*mexp_pkg::DATA_W-1:0]   req_tdata,   // base, exponent
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mexp_pkg::DATA_W-1:0]     rsp_tdata    // power_result
);
   import mexp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_fire;

   assign req_fire = req_tvalid && req_tready;

   mexp_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mexp_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .base       (req_tdata[DATA_W-1:0]),
      .exponent   (req_tdata[2*DATA_W-1:DATA_W]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `MEXP_ASSERT_NOW(a_no_accept_mid_product, clock, reset, req_tready, !cmd.mul_step, "item accepted during a product")
   `MEXP_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.out_load, rsp_tvalid, "loaded result not presented")
   `MEXP_ASSERT_NEXT(a_zero_modulus_skips, clock, reset, req_fire && status.m_zero, !cmd.mul_step, "product started with zero modulus")

endmodule
